@@ hw/rtl/srjb_pkg.sv @@
// ----------------------------------------------------------------------------
// srjb_pkg
// Shared types, codes and widths of the sorted range join buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package srjb_pkg;

  // Field widths of the stream items
  localparam int unsigned OP_W      = 2;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned TDATA_W   = 104;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Parameter defaults
  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_KEY_BITS    = 64;
  localparam int unsigned DEF_HANDLE_BITS = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LOW  = 2'd0,
    CFG_WINDOW_HIGH = 2'd1,
    CFG_LOW_STRICT  = 2'd2,
    CFG_HIGH_STRICT = 2'd3
  } cfg_idx_e;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_RANGE  = 2'd1,
    OP_LATEST = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  // Result outcomes
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_INSERTED = 2'd0,
    OUT_FULL     = 2'd1,
    OUT_MATCH    = 2'd2,
    OUT_NOMATCH  = 2'd3
  } outcome_e;

  // Source of a pushed result
  typedef enum logic [1:0] {
    PUSH_CODE = 2'd0,
    PUSH_PEND = 2'd1,
    PUSH_CUR  = 2'd2
  } push_src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      start;
    logic      rd;
    logic      shift;
    logic      place;
    logic      step;
    logic      push;
    push_src_e push_src;
    logic      push_last;
    outcome_e  push_code;
    logic      pend_load;
    logic      pend_clr;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  in_op;
    op_e  op;
    logic full;
    logic cnt_zero;
    logic pos_zero;
    logic rd_gt;
    logic in_win;
    logic idx_end;
    logic pend_v;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/srjb_dpath.sv @@
// ----------------------------------------------------------------------------
// srjb_dpath
// Sorted table memory, window limits, scan pointer, pending match and output
// register of the sorted range join buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module srjb_dpath import srjb_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BITS    = DEF_KEY_BITS,
  parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  cfg_idx_e             cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [OP_W-1:0]      in_op_i,
  input  logic [KEY_W-1:0]     in_key_i,
  input  logic [HANDLE_W-1:0]  in_handle_i,
  input  logic                 in_left_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [OUTCOME_W-1:0] out_outcome_o,
  output logic [KEY_W-1:0]     out_key_o,
  output logic [HANDLE_W-1:0]  out_handle_o,
  output logic                 out_last_o
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned HW    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int unsigned LIM_W = ((KEY_BITS > 33) ? KEY_BITS : 33) + 1;

  // Configuration registers
  logic signed [CFG_W-1:0] win_lo_q, win_hi_q;
  logic                    lo_strict_q, hi_strict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q    <= '0;
      win_hi_q    <= '0;
      lo_strict_q <= 1'b0;
      hi_strict_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_LOW:  win_lo_q    <= cfg_wdata_i;
        CFG_WINDOW_HIGH: win_hi_q    <= cfg_wdata_i;
        CFG_LOW_STRICT:  lo_strict_q <= cfg_wdata_i[0];
        CFG_HIGH_STRICT: hi_strict_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Table memory
  logic [KEY_BITS-1:0] mem_key [TABLE_DEPTH];
  logic [HW-1:0]       mem_hdl [TABLE_DEPTH];

  logic [CW-1:0]       cnt_q, pos_q;
  logic [AW-1:0]       idx_q;
  op_e                 op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [HW-1:0]       hdl_q;
  logic signed [LIM_W-1:0] lim_lo_q, lim_hi_q;
  logic                lim_lo_s_q, lim_hi_s_q;
  logic [KEY_BITS-1:0] rd_key_q;
  logic [HW-1:0]       rd_hdl_q;
  logic                pend_v_q;
  logic [KEY_BITS-1:0] pend_key_q;
  logic [HW-1:0]       pend_hdl_q;

  logic [CW-1:0] cnt_m1, pos_m1;
  assign cnt_m1 = cnt_q - 1'b1;
  assign pos_m1 = pos_q - 1'b1;

  // Window limits of an incoming probe, one extra bit so they never wrap
  logic [KEY_BITS-1:0]     in_key_k;
  logic signed [LIM_W-1:0] kx, wlx, whx, lo_d, hi_d;
  logic                    use_left;
  assign in_key_k = in_key_i[KEY_BITS-1:0];
  assign kx       = LIM_W'(signed'(in_key_k));
  assign wlx      = LIM_W'(win_lo_q);
  assign whx      = LIM_W'(win_hi_q);
  assign use_left = in_left_i || (op_e'(in_op_i) == OP_LATEST);
  assign lo_d     = use_left ? (kx - whx) : (kx + wlx);
  assign hi_d     = use_left ? (kx - wlx) : (kx + whx);

  // Memory read and write ports
  logic [AW-1:0] raddr, waddr;
  assign raddr = (op_q == OP_INSERT) ? pos_m1[AW-1:0] : idx_q;
  assign waddr = pos_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_key_q <= mem_key[raddr];
      rd_hdl_q <= mem_hdl[raddr];
    end
    if (cmd_i.shift) begin
      mem_key[waddr] <= rd_key_q;
      mem_hdl[waddr] <= rd_hdl_q;
    end else if (cmd_i.place) begin
      mem_key[waddr] <= key_q;
      mem_hdl[waddr] <= hdl_q;
    end
  end

  // Request latch, pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      pos_q    <= '0;
      idx_q    <= '0;
      op_q     <= OP_INSERT;
      pend_v_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        op_q     <= op_e'(in_op_i);
        pos_q    <= cnt_q;
        idx_q    <= (op_e'(in_op_i) == OP_LATEST) ? cnt_m1[AW-1:0] : '0;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.shift) pos_q <= pos_m1;
      if (cmd_i.place) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.step) begin
        idx_q <= (op_q == OP_LATEST) ? idx_q - 1'b1 : idx_q + 1'b1;
      end
      if (cmd_i.pend_load) pend_v_q <= 1'b1;
      else if (cmd_i.pend_clr) pend_v_q <= 1'b0;
    end
  end

  // Payload of the request and pending match
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q      <= in_key_k;
      hdl_q      <= in_handle_i[HW-1:0];
      lim_lo_q   <= lo_d;
      lim_hi_q   <= hi_d;
      lim_lo_s_q <= use_left ? hi_strict_q : lo_strict_q;
      lim_hi_s_q <= use_left ? lo_strict_q : hi_strict_q;
    end
    if (cmd_i.pend_load) begin
      pend_key_q <= rd_key_q;
      pend_hdl_q <= rd_hdl_q;
    end
  end

  // Window test of the entry just read
  logic signed [LIM_W-1:0] sx;
  logic                    ok_lo, ok_hi;
  assign sx    = LIM_W'(signed'(rd_key_q));
  assign ok_lo = lim_lo_s_q ? (sx > lim_lo_q) : (sx >= lim_lo_q);
  assign ok_hi = lim_hi_s_q ? (sx < lim_hi_q) : (sx <= lim_hi_q);

  // Output register
  logic                 out_valid_q;
  logic [OUTCOME_W-1:0] out_outcome_q;
  logic [KEY_BITS-1:0]  out_key_q;
  logic [HW-1:0]        out_hdl_q;
  logic                 out_last_q;
  logic                 out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      case (cmd_i.push_src)
        PUSH_PEND: begin
          out_outcome_q <= OUT_MATCH;
          out_key_q     <= pend_key_q;
          out_hdl_q     <= pend_hdl_q;
          out_last_q    <= cmd_i.push_last;
        end
        PUSH_CUR: begin
          out_outcome_q <= OUT_MATCH;
          out_key_q     <= rd_key_q;
          out_hdl_q     <= rd_hdl_q;
          out_last_q    <= 1'b1;
        end
        default: begin
          out_outcome_q <= cmd_i.push_code;
          out_key_q     <= '0;
          out_hdl_q     <= '0;
          out_last_q    <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_outcome_o = out_outcome_q;
  assign out_key_o     = KEY_W'(signed'(out_key_q));
  assign out_handle_o  = HANDLE_W'(out_hdl_q);
  assign out_last_o    = out_last_q;

  // Status
  assign sts_o.in_op    = op_e'(in_op_i);
  assign sts_o.op       = op_q;
  assign sts_o.full     = (cnt_q >= CW'(TABLE_DEPTH));
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.rd_gt    = (signed'(rd_key_q) > signed'(key_q));
  assign sts_o.in_win   = ok_lo && ok_hi;
  assign sts_o.idx_end  = (op_q == OP_LATEST) ? (idx_q == '0) : ({1'b0, idx_q} == cnt_m1);
  assign sts_o.pend_v   = pend_v_q;
  assign sts_o.out_free = out_free;

endmodule

`default_nettype wire

@@ hw/rtl/srjb_ctrl.sv @@
// ----------------------------------------------------------------------------
// srjb_ctrl
// Sequencer of the sorted range join buffer: insert walk and probe scans.
// ----------------------------------------------------------------------------
`default_nettype none

module srjb_ctrl import srjb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_INS_RD, ST_INS_CMP, ST_SCAN_RD, ST_SCAN_CMP, ST_FLUSH, ST_RESP
  } state_e;

  state_e   state_q, state_d;
  outcome_e code_q, code_d;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    code_d         = code_q;
    cmd_o          = '0;
    cmd_o.push_src = PUSH_CODE;
    cmd_o.push_code = OUT_NOMATCH;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          case (sts_i.in_op)
            OP_INSERT: begin
              if (sts_i.full) begin
                code_d  = OUT_FULL;
                state_d = ST_RESP;
              end else begin
                state_d = ST_INS_RD;
              end
            end
            OP_RANGE, OP_LATEST: begin
              if (sts_i.cnt_zero) begin
                code_d  = OUT_NOMATCH;
                state_d = ST_RESP;
              end else begin
                state_d = ST_SCAN_RD;
              end
            end
            default: begin
              code_d  = OUT_NOMATCH;
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_INS_RD: begin
        if (sts_i.pos_zero) begin
          cmd_o.place = 1'b1;
          code_d      = OUT_INSERTED;
          state_d     = ST_RESP;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        // move a larger key up one place, else drop the new pair here
        if (sts_i.rd_gt) begin
          cmd_o.shift = 1'b1;
          state_d     = ST_INS_RD;
        end else begin
          cmd_o.place = 1'b1;
          code_d      = OUT_INSERTED;
          state_d     = ST_RESP;
        end
      end
      ST_SCAN_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts_i.op == OP_LATEST) begin
          if (sts_i.in_win) begin
            if (sts_i.out_free) begin
              cmd_o.push     = 1'b1;
              cmd_o.push_src = PUSH_CUR;
              state_d        = ST_IDLE;
            end
          end else if (sts_i.idx_end) begin
            code_d  = OUT_NOMATCH;
            state_d = ST_RESP;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = ST_SCAN_RD;
          end
        end else if (!(sts_i.in_win && sts_i.pend_v) || sts_i.out_free) begin
          // hold one match back so the final one can carry tlast
          if (sts_i.in_win) begin
            cmd_o.pend_load = 1'b1;
            if (sts_i.pend_v) begin
              cmd_o.push     = 1'b1;
              cmd_o.push_src = PUSH_PEND;
            end
          end
          if (sts_i.idx_end) begin
            state_d = ST_FLUSH;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = ST_SCAN_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_src  = sts_i.pend_v ? PUSH_PEND : PUSH_CODE;
          cmd_o.push_last = 1'b1;
          cmd_o.pend_clr  = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_code = code_q;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      code_q  <= OUT_NOMATCH;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_range_join_buffer.sv @@
// ----------------------------------------------------------------------------
// sorted_range_join_buffer
// Key-sorted table of (key, row handle) pairs serving a streaming range join.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_axis channel (insert, range probe, latest
// probe) and results leave on the m_axis channel; tlast marks the final
// result of a request. The user sets window bounds and strictness through
// the cfg write port while the block is idle; the block does not enforce it.
// Timing: one request is handled at a time. An insert reads each stored
// entry with a larger key from the top and moves it one place up in the
// single-port table, then places the new pair above the first key that is
// smaller or equal, or at the bottom when there is none. A range probe reads
// every stored entry in turn; a latest probe reads from the top and stops at
// the first hit, or reads every entry on a miss. An empty-table probe, a
// full insert or an unused code is answered without a table read.
// Reset: the table is empty and all window registers are zero; no clearing
// pass is needed.
// Stall: a stalled receiver holds the output register; the scan waits until
// the pending result can be loaded, losing nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_range_join_buffer import srjb_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BITS    = DEF_KEY_BITS,
  parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // operation[1:0], item_key[65:2], row_handle[97:66], zero pad
  input  logic [TDATA_W-1:0] s_axis_tdata,
  // probe_from_left[0]
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // outcome[1:0], match_key[65:2], match_handle[97:66], zero pad
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [KEY_W-1:0]     out_key;
  logic [HANDLE_W-1:0]  out_handle;

  srjb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srjb_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_e'(cfg_idx_i)),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_op_i       (s_axis_tdata[OP_W-1:0]),
    .in_key_i      (s_axis_tdata[OP_W+KEY_W-1:OP_W]),
    .in_handle_i   (s_axis_tdata[OP_W+KEY_W+HANDLE_W-1:OP_W+KEY_W]),
    .in_left_i     (s_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_outcome_o (out_outcome),
    .out_key_o     (out_key),
    .out_handle_o  (out_handle),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {(TDATA_W-OUTCOME_W-KEY_W-HANDLE_W)'(0), out_handle, out_key,
                         out_outcome};

`ifndef SYNTHESIS
  // Never load the output register while it still holds an untaken result
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> sts.out_free) else $error("result pushed over a waiting one");

  // Never write a new pair into a full table
  a_place_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.place |-> !sts.full) else $error("insert into full table");

  // No match may stay pending once a new request can be taken
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !sts.pend_v) else $error("pending match left behind");

  // A flush that clears the pending match always pushes a result
  a_flush_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pend_clr |-> cmd.push) else $error("flush without a result");
`endif

endmodule

`default_nettype wire

@@ bench/sorted_range_join_buffer_test.sv @@
// ----------------------------------------------------------------------------
// sorted_range_join_buffer_test
// Self-checking bench: random and directed requests against a sorted table
// predictor, with random gaps on both stream sides and several window settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

import srjb_pkg::*;

typedef struct {
  outcome_e    outcome;
  logic [63:0] key;
  logic [31:0] handle;
  logic        last;
} join_result_t;

class join_scoreboard;
  logic [63:0]  tbl_key[$];
  logic [31:0]  tbl_handle[$];
  logic [31:0]  win_low, win_high;
  logic         low_strict, high_strict;
  join_result_t pending[$];
  int           errors;

  function new();
    win_low = '0; win_high = '0; low_strict = 0; high_strict = 0; errors = 0;
  endfunction

  function void write_reg(cfg_idx_e idx, logic [31:0] val);
    case (idx)
      CFG_WINDOW_LOW:  win_low = val;
      CFG_WINDOW_HIGH: win_high = val;
      CFG_LOW_STRICT:  low_strict = val[0];
      default:         high_strict = val[0];
    endcase
  endfunction

  function void push_code(outcome_e oc);
    join_result_t r;
    r.outcome = oc; r.key = '0; r.handle = '0; r.last = 1;
    pending.insert(pending.size(), r);
  endfunction

  // Compare in 66-bit signed space so window limits never wrap
  function bit in_win(logic [63:0] s, logic signed [65:0] lo, bit lo_s,
                      logic signed [65:0] hi, bit hi_s);
    logic signed [65:0] sv;
    sv = {{2{s[63]}}, s};
    return (lo_s ? sv > lo : sv >= lo) && (hi_s ? sv < hi : sv <= hi);
  endfunction

  // Note one accepted request and queue the results it causes
  function void note_request(op_e op, logic [63:0] key, logic [31:0] handle, bit left);
    logic signed [65:0] k, wl, wh, lo, hi;
    bit lo_s, hi_s, found;
    int pos;
    join_result_t r;
    k  = {{2{key[63]}}, key};
    wl = {{34{win_low[31]}}, win_low};
    wh = {{34{win_high[31]}}, win_high};
    if (op == OP_INSERT) begin
      if (tbl_key.size() >= DEF_TABLE_DEPTH) begin
        push_code(OUT_FULL);
        return;
      end
      pos = tbl_key.size();
      while (pos > 0 && $signed(tbl_key[pos-1]) > $signed(key)) pos--;
      tbl_key.insert(pos, key);
      tbl_handle.insert(pos, handle);
      push_code(OUT_INSERTED);
      return;
    end
    if (op == OP_UNUSED) begin
      push_code(OUT_NOMATCH);
      return;
    end
    if (left || op == OP_LATEST) begin
      lo = k - wh; lo_s = high_strict; hi = k - wl; hi_s = low_strict;
    end else begin
      lo = k + wl; lo_s = low_strict; hi = k + wh; hi_s = high_strict;
    end
    found = 0;
    r.outcome = OUT_MATCH;
    if (op == OP_LATEST) begin
      for (int i = tbl_key.size() - 1; i >= 0 && !found; i--)
        if (in_win(tbl_key[i], lo, lo_s, hi, hi_s)) begin
          r.key = tbl_key[i]; r.handle = tbl_handle[i]; r.last = 1;
          pending.insert(pending.size(), r);
          found = 1;
        end
    end else begin
      for (int i = 0; i < tbl_key.size(); i++)
        if (in_win(tbl_key[i], lo, lo_s, hi, hi_s)) begin
          r.key = tbl_key[i]; r.handle = tbl_handle[i]; r.last = 0;
          pending.insert(pending.size(), r);
          found = 1;
        end
      if (found) pending[pending.size()-1].last = 1;
    end
    if (!found) push_code(OUT_NOMATCH);
  endfunction

  // Check one accepted result against the oldest expectation
  function void check_result(logic [TDATA_W-1:0] data, logic last);
    join_result_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h last %b", data, last);
      return;
    end
    e = pending.pop_front();
    if (data[1:0] !== e.outcome || data[65:2] !== e.key || data[97:66] !== e.handle
        || data[TDATA_W-1:98] !== '0 || last !== e.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp outcome %0d key %h handle %h last %b, got %0d %h %h %b",
                 e.outcome, e.key, e.handle, e.last, data[1:0], data[65:2],
                 data[97:66], last);
    end
  endfunction
endclass

module sorted_range_join_buffer_test;
  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               s_axis_tvalid = 0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic               s_axis_tuser = 0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  join_scoreboard sb = new();
  bit             sink_quiet = 0;
  logic [63:0]    key_pool[8];

  sorted_range_join_buffer dut (.*);

  always #5 clk_i = ~clk_i;

  // Drain results with random stalls
  initial begin
    int gap;
    forever begin
      gap = (sink_quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Drop the request valid, wait until all results are in, let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_window(logic [31:0] lo, logic [31:0] hi, bit lo_s, bit hi_s);
    wait_idle();
    write_reg(CFG_WINDOW_LOW, lo);
    write_reg(CFG_WINDOW_HIGH, hi);
    write_reg(CFG_LOW_STRICT, {31'd0, lo_s});
    write_reg(CFG_HIGH_STRICT, {31'd0, hi_s});
    cfg_we_i <= 0;
  endtask

  task automatic send_request(op_e op, logic [63:0] key, logic [31:0] handle, bit left,
                              bit eager);
    int gap;
    gap = (eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {6'd0, handle, key, op};
    s_axis_tuser  <= left;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, key, handle, left);
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0, $urandom} >>> 0;
      default: return key_pool[$urandom_range(0, 7)] + 64'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  initial begin
    bit left;
    op_e op;
    logic [63:0] k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, each operation, empty table, duplicates
    send_request(OP_RANGE, 64'd5, 32'd0, 0, 1);
    send_request(OP_LATEST, 64'd5, 32'd0, 1, 1);
    send_request(OP_INSERT, 64'h7fff_ffff_ffff_ffff, 32'hffff_ffff, 0, 1);
    send_request(OP_INSERT, 64'h8000_0000_0000_0000, 32'h0, 1, 1);
    send_request(OP_INSERT, 64'd10, 32'haaaa_5555, 0, 1);
    send_request(OP_INSERT, 64'd10, 32'h5555_aaaa, 0, 1);
    send_request(OP_INSERT, 64'd12, 32'd3, 0, 1);
    send_request(OP_UNUSED, 64'd10, 32'd1, 1, 1);
    set_window(32'hffff_fffe, 32'd2, 0, 0);
    send_request(OP_RANGE, 64'd10, 32'd0, 0, 1);
    send_request(OP_RANGE, 64'd10, 32'd0, 1, 1);
    send_request(OP_LATEST, 64'd10, 32'd0, 0, 1);
    set_window(32'd0, 32'd2, 1, 1);
    send_request(OP_RANGE, 64'd10, 32'd0, 0, 1);
    send_request(OP_RANGE, 64'd8, 32'd0, 0, 1);
    set_window(32'h8000_0000, 32'h7fff_ffff, 0, 0);
    send_request(OP_RANGE, 64'h7fff_ffff_ffff_ffff, 32'd0, 0, 1);
    send_request(OP_RANGE, 64'h8000_0000_0000_0000, 32'd0, 1, 1);
    send_request(OP_LATEST, 64'h8000_0000_0000_0000, 32'd0, 0, 1);
    set_window(32'd5, 32'd1, 0, 0);
    send_request(OP_RANGE, 64'd10, 32'd0, 0, 1);

    // Random phases, with several windows and a full-table phase
    for (int phase = 0; phase < 6; phase++) begin
      for (int j = 0; j < 8; j++) key_pool[j] = {$urandom, $urandom};
      case (phase)
        0: set_window(32'hffff_fff0, 32'd16, 0, 0);
        1: set_window(32'd0, 32'd0, 1, 0);
        2: set_window(32'h8000_0000, 32'h7fff_ffff, 1, 1);
        3: set_window($urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
        4: set_window(32'hffff_ffec, 32'd3, 0, 1);
        default: set_window(32'd20, 32'hffff_fff0, 0, 0);
      endcase
      sink_quiet = (phase == 1);
      for (int n = 0; n < 52; n++) begin
        op = op_e'($urandom_range(0, 9) < 5 ? OP_INSERT : $urandom_range(1, 3));
        if (op == OP_UNUSED && $urandom_range(0, 2) != 0) op = OP_RANGE;
        k = pick_key();
        left = $urandom_range(0, 1);
        send_request(op, k, $urandom, left, phase == 1);
      end
    end
    wait_idle();
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire
